// File: rtl/btlv_pkg.sv
// Package for the BER TLV decoder: phases, kinds, error codes, result type.
// No dependencies.
`timescale 1ns / 1ps
package btlv_pkg;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b0000000001,
    PH_NULL2    = 10'b0000000010,
    PH_INT_LEN  = 10'b0000000100,
    PH_INT_BODY = 10'b0000001000,
    PH_STR_LEN  = 10'b0000010000,
    PH_STR_LLEN = 10'b0000100000,
    PH_STR_BODY = 10'b0001000000,
    PH_OID_LEN  = 10'b0010000000,
    PH_OID_FIRST = 10'b0100000000,
    PH_OID_SUB  = 10'b1000000000
  } phase_e;

  localparam logic [2:0] EK_INT = 3'd0;
  localparam logic [2:0] EK_TT  = 3'd1;
  localparam logic [2:0] EK_STR = 3'd2;
  localparam logic [2:0] EK_OID = 3'd3;
  localparam logic [2:0] EK_NULL = 3'd4;

  localparam logic [2:0] K_STRLEN = 3'd2;
  localparam logic [2:0] K_STRBYTE = 3'd3;
  localparam logic [2:0] K_SUBID  = 3'd4;
  localparam logic [2:0] K_NULL   = 3'd5;
  localparam logic [2:0] K_ERROR  = 3'd6;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_TAG  = 3'd1;
  localparam logic [2:0] E_LEN  = 3'd2;
  localparam logic [2:0] E_TRUNC = 3'd3;
  localparam logic [2:0] E_SUBIDS = 3'd4;
  localparam logic [2:0] E_MALFORMED = 3'd5;

  localparam logic [1:0] REG_TAG_INT = 2'd0;
  localparam logic [1:0] REG_TAG_TT  = 2'd1;
  localparam logic [1:0] REG_TAG_STR = 2'd2;
  localparam logic [1:0] REG_TAG_OID = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
    logic [2:0]  err;
  } result_t;

endpackage

// File: rtl/btlv_out_fifo.sv
// Small result queue between the parser and the master stream side.
// Depends on btlv_pkg.
`timescale 1ns / 1ps
module btlv_out_fifo
  import btlv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push0_i,
  input  result_t data0_i,
  input  logic    push1_i,
  input  result_t data1_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    pop_i
);
  localparam int Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_q, rd_q, wr_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] npush;

  assign npush   = {1'b0, push0_i} + {1'b0, push1_i};
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rd_q];
  // two free slots needed for the worst case beat, not counting this cycle's pop
  assign room_o  = cnt_q <= 3'd2;
  assign cnt_d   = cnt_q + {1'b0, npush} - {2'b0, pop_i & valid_o};
  assign wr_d    = wr_q + npush;

  // store pushed results in order
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
      if (push1_i) mem_q[wr_q + 2'd1] <= data1_i;
    end else if (push1_i) begin
      mem_q[wr_q] <= data1_i;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
      if (pop_i && valid_o) rd_q <= rd_q + 2'd1;
    end
  end
endmodule

// File: rtl/ber_tlv_decoder.sv
// Top level of the BER TLV decoder: byte parser, tag registers, APB port.
// Depends on btlv_pkg and btlv_out_fifo.
`timescale 1ns / 1ps
// Usage:
// Slave stream carries one packet byte per beat; tuser holds expected_kind,
// tlast marks the last byte of the packet. The master stream carries result
// beats: tdata = value, tuser = {error_code, kind}, tlast = last_of_element.
// Each accepted byte is parsed in the cycle it arrives and its zero, one or
// two results are written into a four-entry queue, which registers them on
// the way to the master side. Throughput is one byte per cycle while
// s_axis_tready is high; it drops only when the queue holds more than two
// results, e.g. on receiver stalls. A beat producing two subidentifiers
// leaves two results. Reset returns the parser to waiting for a tag,
// empties the queue and loads the default tags (2, 67, 4, 6). Tag
// registers are written over APB at byte addresses 0, 4, 8, 12; the user
// must do so only while the stream is idle; the block does not enforce it.
module ber_tlv_decoder
  import btlv_pkg::*;
#(
  parameter int MAX_SUBIDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic [2:0]  s_axis_tuser,   // expected_kind
  input  logic        s_axis_tlast,   // packet_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  output logic [5:0]  m_axis_tuser,   // [2:0] kind, [5:3] error_code
  output logic        m_axis_tlast,   // last_of_element
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [7:0] MaxSub = 8'(MAX_SUBIDS);

  logic [7:0] tag_q [4];
  phase_e     ph_q, ph_d;
  logic [2:0] kl_q, kl_d;
  logic [31:0] acc_q, acc_d, rem_q, rem_d;
  logic [2:0] hc_q, hc_d, sbc_q, sbc_d;
  logic [7:0] st_q, st_d;
  logic       disc_q, disc_d;

  logic       acc_in;
  logic [7:0] b;
  logic [6:0] b7;
  logic [2:0] ek;
  logic       pend;
  logic [2:0] err;
  logic       done;
  result_t    r0, r1, o0, o1;
  logic       v0, v1, p0, p1;
  logic [31:0] rem_m1, acc_sh, acc7;
  logic [7:0] tag;
  logic [2:0] q40;
  logic [7:0] r40;
  logic       fifo_room;
  result_t    fo;
  logic [1:0] cfg_idx;

  assign pready = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign prdata = {24'b0, tag_q[cfg_idx]};

  // tag register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[REG_TAG_INT] <= 8'd2;
      tag_q[REG_TAG_TT]  <= 8'd67;
      tag_q[REG_TAG_STR] <= 8'd4;
      tag_q[REG_TAG_OID] <= 8'd6;
    end else if (psel && penable && pwrite) begin
      tag_q[cfg_idx] <= pwdata[7:0];
    end
  end

  assign s_axis_tready = fifo_room;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign b    = s_axis_tdata;
  assign b7   = b[6:0];
  assign ek   = s_axis_tuser;
  assign pend = s_axis_tlast;
  assign rem_m1 = rem_q - 32'd1;
  assign acc_sh = {acc_q[23:0], b};
  assign acc7   = {acc_q[24:0], b7};

  // divide the first oid byte by 40 with a compare ladder
  always_comb begin
    if (b >= 8'd240)      begin q40 = 3'd6; r40 = b - 8'd240; end
    else if (b >= 8'd200) begin q40 = 3'd5; r40 = b - 8'd200; end
    else if (b >= 8'd160) begin q40 = 3'd4; r40 = b - 8'd160; end
    else if (b >= 8'd120) begin q40 = 3'd3; r40 = b - 8'd120; end
    else if (b >= 8'd80)  begin q40 = 3'd2; r40 = b - 8'd80;  end
    else if (b >= 8'd40)  begin q40 = 3'd1; r40 = b - 8'd40;  end
    else                  begin q40 = 3'd0; r40 = b;          end
  end

  assign tag = tag_q[ek[1:0]];

  // parser step
  always_comb begin
    logic [31:0] a;
    logic [2:0]  sc;
    logic [7:0]  tot;
    logic        stop;
    ph_d = ph_q; kl_d = kl_q; acc_d = acc_q; rem_d = rem_q;
    hc_d = hc_q; sbc_d = sbc_q; st_d = st_q; disc_d = disc_q;
    err = E_NONE; done = 1'b0;
    r0 = '0; r1 = '0; v0 = 1'b0; v1 = 1'b0;
    a = acc_q; sc = sbc_q; tot = st_q; stop = 1'b0;
    if (disc_q) begin
      if (pend) begin disc_d = 1'b0; ph_d = PH_IDLE; end
    end else begin
      case (ph_q)
        PH_IDLE: begin
          kl_d = ek;
          if (ek == EK_NULL) begin
            if (pend) err = E_TRUNC; else ph_d = PH_NULL2;
          end else if (ek > EK_NULL || b != tag) err = E_TAG;
          else if (pend) err = E_TRUNC;
          else if (ek == EK_INT || ek == EK_TT) ph_d = PH_INT_LEN;
          else if (ek == EK_STR) ph_d = PH_STR_LEN;
          else ph_d = PH_OID_LEN;
        end
        PH_NULL2: begin
          r0 = '{kind: K_NULL, value: '0, last: 1'b1, err: E_NONE}; v0 = 1'b1;
          done = 1'b1;
        end
        PH_INT_LEN: begin
          if (b > 8'd4) err = E_LEN;
          else if (pend) err = E_TRUNC;
          else begin
            rem_d = (b != 8'd0) ? {24'b0, b} : 32'd1;
            acc_d = '0; ph_d = PH_INT_BODY;
          end
        end
        PH_INT_BODY: begin
          acc_d = acc_sh; rem_d = rem_m1;
          if (rem_m1 == 32'd0) begin
            r0 = '{kind: {2'b0, kl_q[0]}, value: acc_sh, last: 1'b1, err: E_NONE};
            v0 = 1'b1; done = 1'b1;
          end else if (pend) err = E_TRUNC;
        end
        PH_STR_LEN, PH_STR_LLEN: begin
          if (ph_q == PH_STR_LEN && b[7]) begin
            stop = 1'b1;
            if (b7 > 7'd4) err = E_LEN;
            else if (pend) err = E_TRUNC;
            else begin
              hc_d = (b7 != 7'd0) ? b7[2:0] : 3'd1;
              acc_d = '0; ph_d = PH_STR_LLEN;
            end
          end else if (ph_q == PH_STR_LEN) begin
            a = {24'b0, b};
          end else begin
            a = acc_sh; hc_d = hc_q - 3'd1;
            if (hc_q - 3'd1 != 3'd0) begin
              stop = 1'b1; acc_d = a;
              if (pend) err = E_TRUNC;
            end
          end
          if (!stop) begin
            acc_d = a; rem_d = a;
            r0 = '{kind: K_STRLEN, value: a, last: a == 32'd0, err: E_NONE};
            v0 = 1'b1;
            if (a == 32'd0) done = 1'b1;
            else if (pend) err = E_TRUNC;
            else ph_d = PH_STR_BODY;
          end
        end
        PH_STR_BODY: begin
          rem_d = rem_m1;
          r0 = '{kind: K_STRBYTE, value: {24'b0, b}, last: rem_m1 == 32'd0,
                 err: E_NONE};
          v0 = 1'b1;
          if (rem_m1 == 32'd0) done = 1'b1;
          else if (pend) err = E_TRUNC;
        end
        PH_OID_LEN: begin
          if (b == 8'd0) err = E_MALFORMED;
          else if (pend) err = E_TRUNC;
          else begin rem_d = {24'b0, b}; ph_d = PH_OID_FIRST; end
        end
        PH_OID_FIRST: begin
          rem_d = rem_m1;
          r0 = '{kind: K_SUBID, value: {29'b0, q40}, last: 1'b0, err: E_NONE};
          r1 = '{kind: K_SUBID, value: {24'b0, r40}, last: rem_m1 == 32'd0,
                 err: E_NONE};
          v0 = 1'b1; v1 = 1'b1;
          st_d = 8'd2; sbc_d = '0;
          if (rem_m1 == 32'd0) done = 1'b1;
          else if (pend) err = E_TRUNC;
          else ph_d = PH_OID_SUB;
        end
        PH_OID_SUB: begin
          // the byte after four continuation bytes closes the long subid first
          if (sbc_q >= 3'd4) begin
            r0 = '{kind: K_SUBID, value: acc7, last: 1'b0, err: E_NONE};
            v0 = 1'b1; tot = st_q + 8'd1; sc = 3'd0;
          end
          if (sc == 3'd0 && tot >= MaxSub) begin
            err = E_SUBIDS;
          end else begin
            a = (sc == 3'd0) ? {25'b0, b7} : acc7;
            acc_d = a; rem_d = rem_m1;
            if (!b[7]) begin
              r1 = '{kind: K_SUBID, value: a, last: rem_m1 == 32'd0, err: E_NONE};
              v1 = 1'b1; tot = tot + 8'd1; sc = 3'd0;
              if (rem_m1 == 32'd0) done = 1'b1;
              else if (pend) err = E_TRUNC;
            end else begin
              if (rem_m1 == 32'd0) err = E_MALFORMED;
              else if (pend) err = E_TRUNC;
              else sc = sc + 3'd1;
            end
          end
          st_d = tot; sbc_d = sc;
        end
        default: ph_d = PH_IDLE;
      endcase
      if (err != E_NONE) begin
        r0 = '{kind: K_ERROR, value: '0, last: 1'b1, err: err};
        v0 = 1'b1; v1 = 1'b0;
        ph_d = PH_IDLE; disc_d = !pend;
      end else if (done) begin
        ph_d = PH_IDLE;
      end
    end
  end

  // register parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; kl_q <= '0; acc_q <= '0; rem_q <= '0;
      hc_q <= '0; sbc_q <= '0; st_q <= '0; disc_q <= 1'b0;
    end else if (acc_in) begin
      ph_q <= ph_d; kl_q <= kl_d; acc_q <= acc_d; rem_q <= rem_d;
      hc_q <= hc_d; sbc_q <= sbc_d; st_q <= st_d; disc_q <= disc_d;
    end
  end

  assign o0 = r0;
  assign o1 = r1;
  assign p0 = acc_in && v0;
  assign p1 = acc_in && v1;

  btlv_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (p0),
    .data0_i (o0),
    .push1_i (p1),
    .data1_i (o1),
    .room_o  (fifo_room),
    .valid_o (m_axis_tvalid),
    .data_o  (fo),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tdata = fo.value;
  assign m_axis_tuser = {fo.err, fo.kind};
  assign m_axis_tlast = fo.last;

  // an error result always closes its element
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:0] == K_ERROR |-> m_axis_tlast)
    else $error("error result without last");
  // parser phase stays one-hot
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(ph_q))
    else $error("phase not one-hot");
  // a byte accepted in discard mode produces nothing
  a_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && disc_q |-> !p0 && !p1)
    else $error("result while discarding");
endmodule

// File: verif/ber_tlv_decoder_tb.sv
// Self-checking testbench for ber_tlv_decoder: packet bytes in, decoded results out.
// Depends on btlv_pkg and the decoder RTL; a built-in parser predicts every result beat.
`timescale 1ns / 1ps
module ber_tlv_decoder_tb;
  import btlv_pkg::*;

  localparam int MAX_SUBIDS = 16;
  localparam logic [2:0] K_INT = 3'd0;
  localparam logic [2:0] K_TT  = 3'd1;

  typedef struct {
    logic [7:0] b;
    logic [2:0] ek;
    logic       pend;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // byte_in
  logic [2:0]  s_axis_tuser = '0;   // expected_kind
  logic        s_axis_tlast = 1'b0; // packet_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // value
  logic [5:0]  m_axis_tuser;        // [2:0] kind, [5:3] error_code
  logic        m_axis_tlast;        // last_of_element
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ber_tlv_decoder #(.MAX_SUBIDS(MAX_SUBIDS)) dut (.*);

  always #2 clk_i = ~clk_i;

  byte_item_t pending_bytes[$];
  result_t    expected_results[$];
  int         mismatches = 0;
  bit         idling_on = 1'b1;

  // Parser shadow state and tag registers
  logic [7:0]  tag_regs[4] = '{8'd2, 8'd67, 8'd4, 8'd6};
  phase_e      ph = PH_IDLE;
  logic [2:0]  kind_lat = '0;
  logic [31:0] acc = '0;
  logic [31:0] remaining = '0;
  logic [2:0]  hdr_cnt = '0;
  logic [2:0]  sub_bytes = '0;
  logic [7:0]  sub_total = '0;
  bit          discarding = 1'b0;

  function automatic result_t mk(logic [2:0] k, logic [31:0] v, bit l);
    result_t r;
    r.kind = k; r.value = v; r.last = l; r.err = E_NONE;
    return r;
  endfunction

  // Advance the shadow parser by one byte and queue the results it yields
  function automatic void decode_byte(logic [7:0] b, logic [2:0] ek, bit pend);
    result_t    res[$];
    result_t    er;
    logic [2:0] err;
    bit         done;
    bit         emit;
    logic [7:0] tag;
    logic [6:0] lb;
    err = E_NONE; done = 0; emit = 0;
    if (discarding) begin
      if (pend) begin
        discarding = 0;
        ph = PH_IDLE;
      end
      return;
    end
    case (ph)
      PH_IDLE: begin
        kind_lat = ek;
        if (ek == EK_NULL) begin
          if (pend) err = E_TRUNC; else ph = PH_NULL2;
        end else begin
          tag = (ek == EK_INT) ? tag_regs[REG_TAG_INT] : (ek == EK_TT) ? tag_regs[REG_TAG_TT] :
                (ek == EK_STR) ? tag_regs[REG_TAG_STR] : tag_regs[REG_TAG_OID];
          if (ek > EK_NULL || b != tag) err = E_TAG;
          else if (pend) err = E_TRUNC;
          else ph = (ek < EK_STR) ? PH_INT_LEN : (ek == EK_STR) ? PH_STR_LEN : PH_OID_LEN;
        end
      end
      PH_NULL2: begin
        res.push_back(mk(K_NULL, 0, 1));
        done = 1;
      end
      PH_INT_LEN: begin
        if (b > 8'd4) err = E_LEN;
        else if (pend) err = E_TRUNC;
        else begin
          remaining = (b != 0) ? 32'(b) : 32'd1;
          acc = '0;
          ph = PH_INT_BODY;
        end
      end
      PH_INT_BODY: begin
        acc = {acc[23:0], b};
        remaining--;
        if (remaining == 0) begin
          res.push_back(mk(kind_lat[0] ? K_TT : K_INT, acc, 1));
          done = 1;
        end else if (pend) err = E_TRUNC;
      end
      PH_STR_LEN, PH_STR_LLEN: begin
        if (ph == PH_STR_LEN && !b[7]) begin
          acc = 32'(b);
          emit = 1;
        end else if (ph == PH_STR_LEN) begin
          lb = b[6:0];
          if (lb > 7'd4) err = E_LEN;
          else if (pend) err = E_TRUNC;
          else begin
            hdr_cnt = (lb != 0) ? lb[2:0] : 3'd1;
            acc = '0;
            ph = PH_STR_LLEN;
          end
        end else begin
          acc = {acc[23:0], b};
          hdr_cnt = hdr_cnt - 3'd1;
          if (hdr_cnt != 0) begin
            if (pend) err = E_TRUNC;
          end else emit = 1;
        end
        if (emit) begin
          remaining = acc;
          res.push_back(mk(K_STRLEN, acc, acc == 0));
          if (acc == 0) done = 1;
          else if (pend) err = E_TRUNC;
          else ph = PH_STR_BODY;
        end
      end
      PH_STR_BODY: begin
        remaining--;
        res.push_back(mk(K_STRBYTE, 32'(b), remaining == 0));
        if (remaining == 0) done = 1;
        else if (pend) err = E_TRUNC;
      end
      PH_OID_LEN: begin
        if (b == 0) err = E_MALFORMED;
        else if (pend) err = E_TRUNC;
        else begin
          remaining = 32'(b);
          ph = PH_OID_FIRST;
        end
      end
      PH_OID_FIRST: begin
        remaining--;
        res.push_back(mk(K_SUBID, 32'(b / 40), 0));
        res.push_back(mk(K_SUBID, 32'(b % 40), remaining == 0));
        sub_total = 8'd2;
        sub_bytes = '0;
        if (remaining == 0) done = 1;
        else if (pend) err = E_TRUNC;
        else ph = PH_OID_SUB;
      end
      PH_OID_SUB: begin
        // the byte after four continuation bytes closes the long subid and starts a new one
        if (sub_bytes >= 3'd4) begin
          acc = {acc[24:0], b[6:0]};
          res.push_back(mk(K_SUBID, acc, 0));
          sub_total++;
          sub_bytes = '0;
        end
        if (sub_bytes == 0 && sub_total >= MAX_SUBIDS) err = E_SUBIDS;
        else begin
          if (sub_bytes == 0) acc = 32'(b[6:0]);
          else acc = {acc[24:0], b[6:0]};
          remaining--;
          if (!b[7]) begin
            res.push_back(mk(K_SUBID, acc, remaining == 0));
            sub_total++;
            sub_bytes = '0;
            if (remaining == 0) done = 1;
            else if (pend) err = E_TRUNC;
          end else begin
            if (remaining == 0) err = E_MALFORMED;
            else if (pend) err = E_TRUNC;
            else sub_bytes++;
          end
        end
      end
      default: begin
        ph = PH_IDLE;
        return;
      end
    endcase
    if (err != E_NONE) begin
      er = mk(K_ERROR, 0, 1);
      er.err = err;
      res = {er};
      ph = PH_IDLE;
      discarding = !pend;
    end else if (done) ph = PH_IDLE;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  // Byte driver with random idle bursts
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    byte_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          it = pending_bytes.pop_front();
          s_axis_tdata  <= it.b;
          s_axis_tuser  <= it.ek;
          s_axis_tlast  <= it.pend;
          s_axis_tvalid <= 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls
  int sink_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no beat, got kind=%0d value=%0h last=%0b err=%0d", $time,
                   m_axis_tuser[2:0], m_axis_tdata, m_axis_tlast, m_axis_tuser[5:3]);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== m_axis_tuser[2:0] || want.value !== m_axis_tdata ||
              want.last !== m_axis_tlast || want.err !== m_axis_tuser[5:3]) begin
            mismatches++;
            $display("%0t: expected kind=%0d value=%0h last=%0b err=%0d, got %0d %0h %0b %0d",
                     $time, want.kind, want.value, want.last, want.err, m_axis_tuser[2:0],
                     m_axis_tdata, m_axis_tlast, m_axis_tuser[5:3]);
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        sink_stall = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Write one tag register; the shadow copy follows at the access edge
  task automatic write_tag(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(0, 'hFFFF)), 8'h00, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tag_regs[idx] = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic void push_byte(logic [7:0] b, logic [2:0] ek, bit pend);
    byte_item_t it;
    it.b = b; it.ek = ek; it.pend = pend;
    pending_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one element; bad picks an error variant now and then
  function automatic void build_element(ref logic [7:0] pkt[$], ref logic [2:0] eks[$],
                                        input bit bad);
    logic [2:0] ek;
    int         n;
    int         nsub;
    int         nb;
    logic [7:0] body[$];
    ek = 3'($urandom_range(0, 4));
    if (bad && $urandom_range(0, 5) == 0) ek = 3'($urandom_range(5, 7));
    eks.push_back(ek);
    if (ek == EK_NULL) begin
      pkt.push_back(rand_byte()); pkt.push_back(rand_byte());
      return;
    end
    pkt.push_back((bad && $urandom_range(0, 4) == 0) ? rand_byte() :
                  tag_regs[(ek > EK_OID) ? REG_TAG_INT : ek[1:0]]);
    case (ek)
      EK_INT, EK_TT: begin
        n = (bad && $urandom_range(0, 3) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
        pkt.push_back(8'(n));
        repeat ((n == 0) ? 1 : (n > 4 ? 0 : n)) pkt.push_back(rand_byte());
      end
      EK_STR: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 6);
        nb = $urandom_range(0, 4);
        if ($urandom_range(0, 1) == 0 && n < 128) pkt.push_back(8'(n));
        else if (nb == 0) begin
          pkt.push_back(8'h80); pkt.push_back(8'(n));
        end else begin
          pkt.push_back(8'h80 | 8'(nb));
          repeat (nb - 1) pkt.push_back(8'h00);
          pkt.push_back(8'(n));
        end
        if (bad && $urandom_range(0, 4) == 0) pkt.push_back(8'h80 | 8'($urandom_range(5, 127)));
        repeat (n) pkt.push_back(rand_byte());
      end
      default: begin
        body.push_back(rand_byte());
        nsub = (bad && $urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        repeat (nsub) begin
          nb = ($urandom_range(0, 3) == 0) ? 5 : $urandom_range(1, 3);
          repeat (nb - 1) body.push_back(8'h80 | 8'($urandom_range(0, 127)));
          body.push_back(8'($urandom_range(0, 127)));
        end
        if (bad && $urandom_range(0, 4) == 0) body[body.size() - 1][7] = 1'b1;
        pkt.push_back((bad && $urandom_range(0, 5) == 0) ? 8'h00 : 8'(body.size()));
        foreach (body[i]) pkt.push_back(body[i]);
      end
    endcase
  endfunction

  // Queue one packet of elements, possibly cut short; returns its byte count
  function automatic int queue_packet(bit bad);
    logic [7:0] pkt[$];
    logic [2:0] eks[$];
    int         starts[$];
    int         cut;
    int         e;
    repeat ($urandom_range(1, 4)) begin
      starts.push_back(pkt.size());
      build_element(pkt, eks, bad);
    end
    cut = (bad && $urandom_range(0, 1) == 0) ? $urandom_range(1, pkt.size()) : pkt.size();
    e = 0;
    for (int i = 0; i < cut; i++) begin
      if (e < starts.size() && starts[e] == i) begin
        push_byte(pkt[i], eks[e], i == cut - 1);
        e++;
      end else begin
        push_byte(pkt[i], 3'($urandom_range(0, 7)), i == cut - 1);
      end
    end
    return cut;
  endfunction

  // Random traffic: mostly well-formed packets, some broken ones and noise
  task automatic run_traffic(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6))
            push_byte(rand_byte(), 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
          push_byte(rand_byte(), 3'($urandom_range(0, 7)), 1'b1);
          sent += 4;
        end
        1, 2: sent += queue_packet(1'b1);
        default: sent += queue_packet(1'b0);
      endcase
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, every kind and each corner case at default tags
    push_byte(8'd2, EK_INT, 0); push_byte(8'd0, 0, 0); push_byte(8'hFF, 0, 0);
    push_byte(8'd67, EK_TT, 0); push_byte(8'd4, 0, 0);
    push_byte(8'hFF, 0, 0); push_byte(8'hFF, 0, 0); push_byte(8'hFF, 0, 0); push_byte(8'hFF, 0, 0);
    push_byte(8'd4, EK_STR, 0); push_byte(8'd0, 0, 1);
    push_byte(8'd4, EK_STR, 0); push_byte(8'h80, 0, 0); push_byte(8'd1, 0, 0); push_byte(8'hA5, 0, 0);
    push_byte(8'd6, EK_OID, 0); push_byte(8'd1, 0, 0); push_byte(8'hFF, 0, 0);
    push_byte(8'd6, EK_OID, 0); push_byte(8'd0, 0, 1);
    push_byte(8'hAA, EK_NULL, 0); push_byte(8'h55, 7, 0);
    push_byte(8'd2, 3'd5, 1);
    push_byte(8'd2, EK_INT, 0); push_byte(8'd5, 0, 1);
    wait_drained();
    run_traffic(200);

    write_tag(REG_TAG_INT, 8'h00); write_tag(REG_TAG_TT, 8'hFF);
    write_tag(REG_TAG_STR, 8'h00); write_tag(REG_TAG_OID, 8'hFF);
    run_traffic(250);
    write_tag(REG_TAG_INT, 8'hFF); write_tag(REG_TAG_TT, 8'h00);
    write_tag(REG_TAG_STR, 8'hFF); write_tag(REG_TAG_OID, 8'h00);
    run_traffic(250);
    for (int i = 0; i < 4; i++) write_tag(2'(i), rand_byte());
    run_traffic(300);
    write_tag(REG_TAG_INT, 8'd2); write_tag(REG_TAG_TT, 8'd67);
    write_tag(REG_TAG_STR, 8'd4); write_tag(REG_TAG_OID, 8'd6);
    idling_on = 1'b0;
    run_traffic(300);

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
